// ===== rtl/core/rvmiu_pkg.sv =====
// Shared types and constants for the register VM instruction unit.
package rvmiu_pkg;

  localparam int DATA_W        = 32;
  localparam int REG_IDX_W     = 5;
  localparam int OFFSET_W      = 16;
  localparam int DEF_REG_COUNT = 32;
  localparam int DIV_STEPS     = DATA_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    OP_CONST = 4'd0,
    OP_MOV   = 4'd1,
    OP_JMP   = 4'd2,
    OP_JLT   = 4'd3,
    OP_JEQ   = 4'd4,
    OP_ADD   = 4'd5,
    OP_MOD   = 4'd6,
    OP_NOP   = 4'd7,
    OP_END   = 4'd8
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/register_vm_instruction_unit.sv =====
// Execute unit of a small register VM: register file, sequencer and serial divider.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one instruction item: opcode,
//   reg_a, reg_b, reg_c, immediate and jump_offset. Output channel
//   (out_valid/out_ready) returns one item per instruction: pc_step, halted
//   and fault.
//   The unit takes one instruction at a time; in_ready is high only while
//   the sequencer is idle. The result sits in an output register, so a new
//   instruction is taken while the previous result still waits downstream.
//   Sequence: const, mov, add, jumps, nop and end pass execute and done,
//   then load the output register. mod runs 32 restoring divider steps
//   between operand load and sign fixup, then the same handoff. A zero
//   divisor skips the divider and returns fault through done.
//   Register reads come from a memory with registered read data, captured
//   at the accept edge; writes go back through its single write port.
//   Reset (rst, synchronous) returns the sequencer to idle and drops
//   out_valid. Register contents are not cleared and must be written first.
//   If the receiver stalls, the finished result waits in the sequencer until
//   the output register frees up; no further instruction is taken meanwhile.
module register_vm_instruction_unit #(
  parameter int REG_COUNT = rvmiu_pkg::DEF_REG_COUNT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [3:0]                            opcode,
  input  logic [rvmiu_pkg::REG_IDX_W-1:0]       reg_a,
  input  logic [rvmiu_pkg::REG_IDX_W-1:0]       reg_b,
  input  logic [rvmiu_pkg::REG_IDX_W-1:0]       reg_c,
  input  logic signed [rvmiu_pkg::DATA_W-1:0]   immediate,
  input  logic signed [rvmiu_pkg::OFFSET_W-1:0] jump_offset,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rvmiu_pkg::OFFSET_W-1:0] pc_step,
  output logic                                  halted,
  output logic                                  fault
);

  localparam int ADDR_W = $clog2(REG_COUNT);
  localparam int DW     = rvmiu_pkg::DATA_W;
  localparam int OW     = rvmiu_pkg::OFFSET_W;

  // Register file: one write port, two registered read ports.
  logic [DW-1:0] mem [REG_COUNT];

  rvmiu_pkg::state_t  state, state_next;
  rvmiu_pkg::opcode_t op;

  // Latched instruction fields
  logic [ADDR_W-1:0] wa;
  logic              wa_ok;
  logic [DW-1:0]     imm;
  logic [OW-1:0]     joff;

  // Operand read
  logic              accept;
  logic              is_cmp;
  logic [rvmiu_pkg::REG_IDX_W-1:0] rsel1, rsel2;
  logic [DW-1:0]     rd1, rd2;
  logic              v1, v2;
  logic [DW-1:0]     a1, a2;

  // Write port
  logic              we;
  logic [DW-1:0]     wdata;

  // Result held until the output register is free
  logic [OW-1:0]     res_step;
  logic              res_halt;
  logic              res_fault;

  // Serial divider
  logic [DW-1:0]     rem, quo, dmag;
  logic              xneg;
  logic [rvmiu_pkg::DIV_CNT_W-1:0] cnt;
  logic [DW:0]       shifted, diff;
  logic              ge;
  logic [DW-1:0]     rem_next;

  assign in_ready = (state == rvmiu_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Compares read reg_a/reg_b; arithmetic reads reg_b/reg_c.
  assign is_cmp = (opcode == rvmiu_pkg::OP_JLT) || (opcode == rvmiu_pkg::OP_JEQ);
  assign rsel1  = is_cmp ? reg_a : reg_b;
  assign rsel2  = is_cmp ? reg_b : reg_c;

  // Out-of-range register reads as zero
  assign a1 = v1 ? rd1 : '0;
  assign a2 = v2 ? rd2 : '0;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wdata;
    end
    if (accept) begin
      rd1 <= mem[ADDR_W'(rsel1)];
      rd2 <= mem[ADDR_W'(rsel2)];
    end
  end

  // One restoring step per cycle
  assign shifted  = {rem, quo[DW-1]};
  assign ge       = shifted >= {1'b0, dmag};
  assign diff     = shifted - {1'b0, dmag};
  assign rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rvmiu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    wdata      = a1;
    case (state)
      rvmiu_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = rvmiu_pkg::ST_EXEC;
        end
      end
      rvmiu_pkg::ST_EXEC: begin
        state_next = rvmiu_pkg::ST_DONE;
        case (op)
          rvmiu_pkg::OP_CONST: begin
            we    = wa_ok;
            wdata = imm;
          end
          rvmiu_pkg::OP_MOV: begin
            we    = wa_ok;
            wdata = a1;
          end
          rvmiu_pkg::OP_ADD: begin
            we    = wa_ok;
            wdata = a1 + a2;
          end
          rvmiu_pkg::OP_MOD: begin
            if (a2 != '0) begin
              state_next = rvmiu_pkg::ST_DIV;
            end
          end
          default: begin
          end
        endcase
      end
      rvmiu_pkg::ST_DIV: begin
        if (cnt == rvmiu_pkg::DIV_CNT_W'(rvmiu_pkg::DIV_STEPS - 1)) begin
          state_next = rvmiu_pkg::ST_FIX;
        end
      end
      rvmiu_pkg::ST_FIX: begin
        // Remainder takes the dividend's sign
        we         = wa_ok;
        wdata      = xneg ? (DW'(0) - rem) : rem;
        state_next = rvmiu_pkg::ST_DONE;
      end
      rvmiu_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = rvmiu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rvmiu_pkg::ST_IDLE;
      end
    endcase
  end

  // Instruction latch, result and divider datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= rvmiu_pkg::opcode_t'(opcode);
      wa    <= ADDR_W'(reg_a);
      wa_ok <= 32'(reg_a) < REG_COUNT;
      v1    <= 32'(rsel1) < REG_COUNT;
      v2    <= 32'(rsel2) < REG_COUNT;
      imm   <= immediate;
      joff  <= jump_offset;
    end
    if (state == rvmiu_pkg::ST_EXEC) begin
      res_step  <= OW'(1);
      res_halt  <= 1'b0;
      res_fault <= 1'b0;
      case (op)
        rvmiu_pkg::OP_JMP: begin
          res_step <= joff;
        end
        rvmiu_pkg::OP_JLT: begin
          if (!($signed(a1) < $signed(a2))) begin
            res_step <= joff;
          end
        end
        rvmiu_pkg::OP_JEQ: begin
          if (a1 != a2) begin
            res_step <= joff;
          end
        end
        rvmiu_pkg::OP_MOD: begin
          res_fault <= (a2 == '0);
        end
        rvmiu_pkg::OP_END: begin
          res_step <= '0;
          res_halt <= 1'b1;
        end
        default: begin
        end
      endcase
      // Divider operands as magnitudes
      xneg <= a1[DW-1];
      quo  <= a1[DW-1] ? (DW'(0) - a1) : a1;
      dmag <= a2[DW-1] ? (DW'(0) - a2) : a2;
      rem  <= '0;
      cnt  <= '0;
    end else if (state == rvmiu_pkg::ST_DIV) begin
      rem <= rem_next;
      quo <= {quo[DW-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rvmiu_pkg::ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rvmiu_pkg::ST_DONE && (!out_valid || out_ready)) begin
      pc_step <= res_step;
      halted  <= res_halt;
      fault   <= res_fault;
    end
  end

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == rvmiu_pkg::ST_EXEC)
    else $error("accepted item did not enter execute");

  a_fix_after_div: assert property (@(posedge clk) disable iff (rst)
    state == rvmiu_pkg::ST_FIX |-> $past(state) == rvmiu_pkg::ST_DIV)
    else $error("sign fixup without divider run");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    we |-> state != rvmiu_pkg::ST_IDLE && state != rvmiu_pkg::ST_DONE)
    else $error("register write outside execute");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == rvmiu_pkg::ST_DIV |-> rem < dmag)
    else $error("partial remainder not below divisor");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(halted && fault))
    else $error("halt and fault both set");
`endif

endmodule
